### hdl/crcb_pkg.sv
`default_nettype none

package crcb_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_POLY        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_OUT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_IN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUT = 3'd5;

	// Reset values: CRC-32 as used by Ethernet and zip
	localparam logic [31:0] POLY_RST        = 32'h04C1_1DB7;
	localparam logic [31:0] INIT_VALUE_RST  = 32'hFFFF_FFFF;
	localparam logic [31:0] XOR_OUT_RST     = 32'hFFFF_FFFF;
	localparam logic [5:0]  CRC_WIDTH_RST   = 6'd32;
	localparam logic        REFLECT_IN_RST  = 1'b1;
	localparam logic        REFLECT_OUT_RST = 1'b1;

	localparam logic [5:0]  MIN_CRC_WIDTH   = 6'd8;

	typedef struct packed {
		logic [31:0] poly;
		logic [31:0] init_value;
		logic [31:0] xor_out;
		logic [5:0]  crc_width;
		logic        reflect_in;
		logic        reflect_out;
	} crcb_cfg_t;

endpackage

`default_nettype wire

### hdl/crcb_cfg.sv
`default_nettype none

module crcb_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [crcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	output crcb_pkg::crcb_cfg_t                cfg
);

	crcb_pkg::crcb_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly        <= crcb_pkg::POLY_RST;
			cfg_q.init_value  <= crcb_pkg::INIT_VALUE_RST;
			cfg_q.xor_out     <= crcb_pkg::XOR_OUT_RST;
			cfg_q.crc_width   <= crcb_pkg::CRC_WIDTH_RST;
			cfg_q.reflect_in  <= crcb_pkg::REFLECT_IN_RST;
			cfg_q.reflect_out <= crcb_pkg::REFLECT_OUT_RST;
		end else if (cfg_valid) begin
			// unknown indexes drop the write
			unique case (cfg_index)
				crcb_pkg::CFG_POLY:        cfg_q.poly        <= cfg_data;
				crcb_pkg::CFG_INIT_VALUE:  cfg_q.init_value  <= cfg_data;
				crcb_pkg::CFG_XOR_OUT:     cfg_q.xor_out     <= cfg_data;
				crcb_pkg::CFG_CRC_WIDTH:   cfg_q.crc_width   <= cfg_data[5:0];
				crcb_pkg::CFG_REFLECT_IN:  cfg_q.reflect_in  <= cfg_data[0];
				crcb_pkg::CFG_REFLECT_OUT: cfg_q.reflect_out <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/crcb_update.sv
`default_nettype none

module crcb_update #(
	parameter int MAX_WIDTH = 32
) (
	input  wire crcb_pkg::crcb_cfg_t  cfg,
	input  wire logic [5:0]           shift_amt,
	input  wire logic [MAX_WIDTH-1:0] mask,
	input  wire logic [MAX_WIDTH-1:0] crc_in,
	input  wire logic [7:0]           data,
	output logic [MAX_WIDTH-1:0]      crc_out
);

	always_comb begin
		logic [MAX_WIDTH-1:0] c;
		logic [MAX_WIDTH-1:0] p;
		logic [MAX_WIDTH-1:0] p_rev;
		logic [MAX_WIDTH-1:0] rp;
		logic [MAX_WIDTH-1:0] ca;
		logic [MAX_WIDTH-1:0] pa;

		c = crc_in & mask;
		p = cfg.poly[MAX_WIDTH-1:0] & mask;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			p_rev[MAX_WIDTH-1-i] = p[i];
		end
		rp = p_rev >> shift_amt;
		ca = c << shift_amt;
		pa = p << shift_amt;

		if (cfg.reflect_in) begin
			// LSB first against the reflected polynomial
			c = c ^ MAX_WIDTH'(data);
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
			end
			crc_out = c;
		end else begin
			// MSB first, worked top-aligned so the MSB sits at a fixed bit
			ca = ca ^ (MAX_WIDTH'(data) << (MAX_WIDTH - 8));
			for (int k = 0; k < 8; k++) begin
				ca = ca[MAX_WIDTH-1] ? ((ca << 1) ^ pa) : (ca << 1);
			end
			crc_out = ca >> shift_amt;
		end
	end

endmodule

`default_nettype wire

### hdl/crcb_finish.sv
`default_nettype none

module crcb_finish #(
	parameter int MAX_WIDTH = 32
) (
	input  wire crcb_pkg::crcb_cfg_t  cfg,
	input  wire logic [5:0]           shift_amt,
	input  wire logic [MAX_WIDTH-1:0] mask,
	input  wire logic [MAX_WIDTH-1:0] crc_in,
	output logic [MAX_WIDTH-1:0]      crc_out
);

	always_comb begin
		logic [MAX_WIDTH-1:0] c_rev;
		logic [MAX_WIDTH-1:0] r;

		for (int i = 0; i < MAX_WIDTH; i++) begin
			c_rev[MAX_WIDTH-1-i] = crc_in[i];
		end
		// reflect over the effective width only when the two flags differ
		r = (cfg.reflect_in != cfg.reflect_out) ? (c_rev >> shift_amt) : crc_in;
		crc_out = (r ^ cfg.xor_out[MAX_WIDTH-1:0]) & mask;
	end

endmodule

`default_nettype wire

### hdl/configurable_crc_bytewise.sv
`default_nettype none

// Byte-wide CRC engine, width 8 to MAX_WIDTH bits, with a run-time choice of
// polynomial, seed, final XOR and bit order. Send the message one byte per
// transfer on s_axis, with s_axis_tlast on the final byte; that transfer
// alone yields one m_axis transfer carrying the finished CRC, zero-extended
// to 32 bits. The engine takes one byte every clock: the running CRC register
// closes a loop through an unrolled eight-bit update, and a final byte passes
// through the input stage and then the result register. Back pressure on m_axis
// stalls the input only when a final byte finds the result register full.
// Program the registers on the cfg channel (index 0 poly, 1 init_value,
// 2 xor_out, 3 crc_width, 4 reflect_in, 5 reflect_out) between messages;
// out-of-range widths clamp to 8 or MAX_WIDTH, and the result is bit-reversed
// when reflect_in differs from reflect_out. Reset loads the CRC-32 settings.
module configurable_crc_bytewise #(
	parameter int MAX_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// message bytes
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  wire logic                           s_axis_tlast,  // last_byte

	// finished CRC
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [31:0]                         m_axis_tdata,  // [31:0] crc_value

	// register writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [crcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	crcb_pkg::crcb_cfg_t cfg;

	// input stage
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	// running CRC and message-in-progress flag
	logic [MAX_WIDTH-1:0] crc_q;
	logic                 busy_q;

	// result stage
	logic                 valid_s2;
	logic [MAX_WIDTH-1:0] crc_s2;

	logic [5:0]           eff_width;
	logic [5:0]           shift_amt;
	logic [MAX_WIDTH-1:0] mask;
	logic [MAX_WIDTH-1:0] crc_start;
	logic [MAX_WIDTH-1:0] crc_next;
	logic [MAX_WIDTH-1:0] crc_final;
	logic                 s1_fire;

	crcb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Clamp the width and derive the alignment shift and the width mask.
	always_comb begin
		if (cfg.crc_width < crcb_pkg::MIN_CRC_WIDTH) begin
			eff_width = crcb_pkg::MIN_CRC_WIDTH;
		end else if (cfg.crc_width > 6'(MAX_WIDTH)) begin
			eff_width = 6'(MAX_WIDTH);
		end else begin
			eff_width = cfg.crc_width;
		end
		shift_amt = 6'(MAX_WIDTH) - eff_width;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			mask[i] = (6'(i) < eff_width);
		end
	end

	// A new message starts from the seed in force when its first byte is processed.
	assign crc_start = busy_q ? crc_q : cfg.init_value[MAX_WIDTH-1:0];

	crcb_update #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_update (
		.cfg       (cfg),
		.shift_amt (shift_amt),
		.mask      (mask),
		.crc_in    (crc_start),
		.data      (byte_s1),
		.crc_out   (crc_next)
	);

	crcb_finish #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_finish (
		.cfg       (cfg),
		.shift_amt (shift_amt),
		.mask      (mask),
		.crc_in    (crc_next),
		.crc_out   (crc_final)
	);

	// Advance the input stage unless a final byte would land on a result still
	// waiting for its transfer.
	assign s1_fire       = valid_s1 && (!last_s1 || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			busy_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s1_fire) begin
				busy_q <= !last_s1;
			end
			if (s1_fire && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (s1_fire) begin
			crc_q <= crc_next;
		end
		if (s1_fire && last_s1) begin
			crc_s2 <= crc_final;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = 32'(crc_s2);

endmodule

`default_nettype wire
